@@ hdl/deadline_io_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef DEADLINE_IO_SCHEDULER_DEFINES_SVH
`define DEADLINE_IO_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DIOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dios_pkg.sv @@
package dios_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam int SECTOR_W  = 48;
    localparam int TAG_W     = 8;
    localparam int TIME_W    = 32;
    localparam int ORDER_W   = 32;
    localparam int DL_W      = 16;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXP_READ  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXP_WRITE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SORTED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TICK      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_DL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_DL = 8'd1;

    localparam logic [DL_W-1:0] READ_DL_RST  = 16'd500;
    localparam logic [DL_W-1:0] WRITE_DL_RST = 16'd5000;

    // One stored request.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                is_write;
        logic [TAG_BITS-1:0] tag;
        logic [TIME_W-1:0]   arrival;
        logic [ORDER_W-1:0]  order;
    } t_entry;

    // Best entry seen so far in a scan, with the fields needed on dispatch.
    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    idx;
        logic [ORDER_W-1:0]  ord_dist;
        logic [SECTOR_W-1:0] sector;
        logic                is_write;
        logic [TAG_BITS-1:0] tag;
        logic [TIME_W-1:0]   arrival;
    } t_cand;

    typedef struct packed {
        t_cand rd;
        t_cand wr;
        t_cand lo;
    } t_best;

endpackage

@@ hdl/deadline_io_scheduler.sv @@
// Deadline I/O scheduler: holds up to QUEUE_DEPTH pending block requests.
// Input channel (i_valid/o_ready): one item is a command with its fields.
//   add stores a request in the lowest free entry (status added or full),
//   dispatch removes at most one request, tick advances the millisecond counter.
// Output channel (o_valid/i_ready): exactly one result item per input item.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets the
//   read deadline, index 1 the write deadline; other indexes are ignored.
//   Write only while the block is idle.
// Add, tick and the unused command pass through S_EXEC and S_RESULT from
//   accept to result; dispatch adds S_SCAN, which walks the table one entry
//   a cycle through a single compare unit, and then S_CHECK for the deadline
//   check, before S_RESULT.
// One item is in work at a time; o_ready is high only when idle. A finished
//   result waits in the output register, and the next item can be accepted
//   meanwhile; its own result waits until the receiver takes the first.
// Reset empties the table, zeroes the tick counter and the arrival sequence,
//   and restores the deadlines to 500 and 5000 ticks.
module deadline_io_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dios_pkg::CMD_W-1:0]        i_command,
    input  logic [dios_pkg::SECTOR_W-1:0]     i_sector,
    input  logic                              i_is_write,
    input  logic [dios_pkg::TAG_W-1:0]        i_tag,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dios_pkg::STATUS_W-1:0]     o_status,
    output logic [dios_pkg::TAG_W-1:0]        o_out_tag,
    output logic [dios_pkg::SECTOR_W-1:0]     o_out_sector,
    output logic                              o_out_is_write,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dios_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dios_pkg::DL_W-1:0]         i_cfg_data
);
    import dios_pkg::*;

    `include "deadline_io_scheduler_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CHECK,
        S_RESULT
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [SECTOR_W-1:0] r_sector;
    logic                r_is_write;
    logic [TAG_BITS-1:0] r_tag;
    logic [DL_W-1:0]     r_read_dl;
    logic [DL_W-1:0]     r_write_dl;
    logic [TIME_W-1:0]   r_now;
    logic [ORDER_W-1:0]  r_next_order;
    logic [IDX_W-1:0]    r_idx;
    t_best               r_best;
    logic [STATUS_W-1:0] r_status;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [TAG_W-1:0]    r_o_tag;
    logic [SECTOR_W-1:0] r_o_sector;
    logic                r_o_write;

    t_best                  n_best;
    t_entry                 rd_entry;
    logic                   rd_valid;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   wr_en;
    t_entry                 wr_entry;
    logic                   out_free;
    t_cand                  res_cand;
    logic                   res_take;
    logic                   clr_en;
    logic [TIME_W-1:0]      age_rd;
    logic [TIME_W-1:0]      age_wr;
    logic                   rd_exp;
    logic                   wr_exp;

    dios_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (free_idx),
        .i_wr_entry (wr_entry),
        .i_clr_en   (clr_en),
        .i_clr_idx  (res_cand.idx),
        .i_rd_idx   (r_idx),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid),
        .o_valid    (valid_vec)
    );

    // Shared compare unit, one table entry per cycle.
    dios_cmp u_cmp (
        .i_entry      (rd_entry),
        .i_valid      (rd_valid),
        .i_idx        (r_idx),
        .i_next_order (r_next_order),
        .i_best       (r_best),
        .o_best       (n_best)
    );

    // Lowest free entry for an add.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_vec[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign wr_en = (r_state == S_EXEC) && (r_cmd == CMD_ADD) && free_found;

    always_comb begin
        wr_entry.sector   = r_sector;
        wr_entry.is_write = r_is_write;
        wr_entry.tag      = r_tag;
        wr_entry.arrival  = r_now;
        wr_entry.order    = r_next_order;
    end

    // Deadline check on the oldest read and oldest write, ages mod 2^32.
    assign age_rd = r_now - r_best.rd.arrival;
    assign age_wr = r_now - r_best.wr.arrival;
    assign rd_exp = r_best.rd.found && (age_rd >= TIME_W'(r_read_dl));
    assign wr_exp = r_best.wr.found && (age_wr >= TIME_W'(r_write_dl));

    // Result source chosen by the status decided earlier.
    always_comb begin
        res_cand = '0;
        res_take = 1'b0;
        case (r_status)
            ST_EXP_READ: begin
                res_cand = r_best.rd;
                res_take = 1'b1;
            end
            ST_EXP_WRITE: begin
                res_cand = r_best.wr;
                res_take = 1'b1;
            end
            ST_SORTED: begin
                res_cand = r_best.lo;
                res_take = 1'b1;
            end
            default: begin
                res_cand = '0;
                res_take = 1'b0;
            end
        endcase
    end

    assign out_free = !r_o_valid || i_ready;
    assign clr_en   = (r_state == S_RESULT) && out_free && res_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmd        <= CMD_ADD;
            r_sector     <= '0;
            r_is_write   <= 1'b0;
            r_tag        <= '0;
            r_read_dl    <= READ_DL_RST;
            r_write_dl   <= WRITE_DL_RST;
            r_now        <= '0;
            r_next_order <= '0;
            r_idx        <= '0;
            r_best       <= '0;
            r_status     <= ST_EMPTY;
            r_o_valid    <= 1'b0;
            r_o_status   <= ST_EMPTY;
            r_o_tag      <= '0;
            r_o_sector   <= '0;
            r_o_write    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_READ_DL:  r_read_dl  <= i_cfg_data;
                    CFG_WRITE_DL: r_write_dl <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // In S_RESULT the output register is reloaded below instead.
            if (r_o_valid && i_ready && (r_state != S_RESULT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= i_command;
                        r_sector   <= i_sector;
                        r_is_write <= i_is_write;
                        r_tag      <= TAG_BITS'(i_tag);
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_idx   <= '0;
                    r_best  <= '0;
                    r_state <= S_RESULT;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (free_found) begin
                                r_next_order <= r_next_order + ORDER_W'(1);
                                r_status     <= ST_ADDED;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        CMD_DISPATCH: begin
                            r_state <= S_SCAN;
                        end
                        CMD_TICK: begin
                            r_now    <= r_now + TIME_W'(1);
                            r_status <= ST_TICK;
                        end
                        default: begin
                            r_status <= ST_EMPTY;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_best <= n_best;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_CHECK: begin
                    if (rd_exp) begin
                        r_status <= ST_EXP_READ;
                    end else if (wr_exp) begin
                        r_status <= ST_EXP_WRITE;
                    end else if (r_best.lo.found) begin
                        r_status <= ST_SORTED;
                    end else begin
                        r_status <= ST_EMPTY;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_tag    <= TAG_W'(res_cand.tag);
                        r_o_sector <= res_cand.sector;
                        r_o_write  <= res_cand.is_write;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_tag      = r_o_tag;
    assign o_out_sector   = r_o_sector;
    assign o_out_is_write = r_o_write;

    `DIOS_ASSERT_IMPL(a_exp_read_dir, i_clk, i_rst_n, r_o_valid && (r_o_status == ST_EXP_READ), !r_o_write, "expired read result carries a write")
    `DIOS_ASSERT_IMPL(a_exp_write_dir, i_clk, i_rst_n, r_o_valid && (r_o_status == ST_EXP_WRITE), r_o_write, "expired write result carries a read")
    `DIOS_ASSERT_IMPL(a_no_pick_zero, i_clk, i_rst_n, r_o_valid && (r_o_status == ST_ADDED || r_o_status == ST_FULL || r_o_status == ST_TICK || r_o_status == ST_EMPTY), (r_o_tag == '0) && (r_o_sector == '0) && !r_o_write, "non-dispatch result has nonzero fields")
    `DIOS_ASSERT_NEXT(a_order_step, i_clk, i_rst_n, wr_en, r_next_order == $past(r_next_order) + ORDER_W'(1), "arrival sequence did not advance on add")
    `DIOS_ASSERT_IMPL(a_idx_idle, i_clk, i_rst_n, r_state != S_SCAN, r_idx == '0, "scan index nonzero outside scan")

endmodule

@@ hdl/dios_table.sv @@
module dios_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [dios_pkg::IDX_W-1:0]    i_wr_idx,
    input  dios_pkg::t_entry              i_wr_entry,
    input  logic                          i_clr_en,
    input  logic [dios_pkg::IDX_W-1:0]    i_clr_idx,
    input  logic [dios_pkg::IDX_W-1:0]    i_rd_idx,
    output dios_pkg::t_entry              o_rd_entry,
    output logic                          o_rd_valid,
    output logic [dios_pkg::QUEUE_DEPTH-1:0] o_valid
);
    import dios_pkg::*;

    t_entry                 r_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_valid;

    // Valid bits: set on add, cleared on dispatch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
        end
    end

    // Payload is only read where the valid bit is set, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry[i_wr_idx] <= i_wr_entry;
        end
    end

    assign o_rd_entry = r_entry[i_rd_idx];
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_valid    = r_valid;

endmodule

@@ hdl/dios_cmp.sv @@
module dios_cmp (
    input  dios_pkg::t_entry                i_entry,
    input  logic                            i_valid,
    input  logic [dios_pkg::IDX_W-1:0]      i_idx,
    input  logic [dios_pkg::ORDER_W-1:0]    i_next_order,
    input  dios_pkg::t_best                 i_best,
    output dios_pkg::t_best                 o_best
);
    import dios_pkg::*;

    logic [ORDER_W-1:0] cur_dist;
    t_cand              cand;

    // Larger distance from next_order means older, also across wrap.
    assign cur_dist = i_next_order - i_entry.order;

    always_comb begin
        cand.found    = 1'b1;
        cand.idx      = i_idx;
        cand.ord_dist = cur_dist;
        cand.sector   = i_entry.sector;
        cand.is_write = i_entry.is_write;
        cand.tag      = i_entry.tag;
        cand.arrival  = i_entry.arrival;

        o_best = i_best;
        if (i_valid && !i_entry.is_write &&
            (!i_best.rd.found || cur_dist > i_best.rd.ord_dist)) begin
            o_best.rd = cand;
        end
        if (i_valid && i_entry.is_write &&
            (!i_best.wr.found || cur_dist > i_best.wr.ord_dist)) begin
            o_best.wr = cand;
        end
        if (i_valid && (!i_best.lo.found || i_entry.sector < i_best.lo.sector ||
                        (i_entry.sector == i_best.lo.sector &&
                         cur_dist > i_best.lo.ord_dist))) begin
            o_best.lo = cand;
        end
    end

endmodule
